FILE: rtl/iats_pkg.sv
// ----------------------------------------------------------------------------
// iats_pkg
// Shared types, constants and helpers of the injector angle-to-tick scheduler.
// ----------------------------------------------------------------------------
package iats_pkg;

  localparam int MAX_INJECTORS       = 6;
  localparam int ANGLE_FRACTION_BITS = 6;

  // one engine cycle, 720 degrees, in 1/64 degree
  localparam logic signed [19:0] CYCLE_UNITS = 20'sd46080;
  localparam logic [15:0] HALF_CYCLE_UNITS   = 16'd23040;
  localparam logic [14:0] CAM_HALF_UNITS     = 15'd11520;
  localparam logic [15:0] DEG360_UNITS       = 16'd23040;

  localparam logic [8:0]  DEG360             = 9'd360;
  localparam logic [46:0] PULSE_ROUND        = 47'd500000;
  // 1000000 = 64 * 15625: shift by six, then multiply by ceil(2^54 / 15625)
  // and keep the bits from 54 up; exact for any 41-bit dividend
  localparam logic [20:0] RECIP_HI           = 21'd549755;
  localparam logic [20:0] RECIP_LO           = 21'd1706847;
  localparam logic [2:0]  DIV_LAST_STEP      = 3'd3;

  localparam logic [2:0]  INJ_COUNT_RESET    = 3'd4;
  localparam logic [26:0] TPS_RESET          = 27'd1000000;

  typedef logic [MAX_INJECTORS-1:0][9:0] tdc_array_t;

  typedef enum logic [2:0] {
    REG_INJ_COUNT = 3'd0,
    REG_TPS       = 3'd1,
    REG_TDC0      = 3'd2,
    REG_TDC1      = 3'd3,
    REG_TDC2      = 3'd4,
    REG_TDC3      = 3'd5,
    REG_TDC4      = 3'd6,
    REG_TDC5      = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    ACT_NONE         = 3'd0,
    ACT_CANCEL       = 3'd1,
    ACT_SKIP_PENDING = 3'd2,
    ACT_SKIP_PASSED  = 3'd3,
    ACT_OPEN_ONLY    = 3'd4,
    ACT_OPEN_CLOSE   = 3'd5,
    ACT_BAD_INDEX    = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    K_NOSYNC = 2'd0,
    K_BADIDX = 2'd1,
    K_CANCEL = 2'd2,
    K_RUN    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    B_IDLE   = 2'd0,
    B_MUL    = 2'd1,
    B_DIV    = 2'd2,
    B_DECIDE = 2'd3
  } bstate_t;

  typedef struct packed {
    kind_t       kind;
    logic [2:0]  idx;
    logic [32:0] tpd;
    logic [15:0] deg;
    logic [31:0] now;
    logic [19:0] pulse;
  } job_t;

  // wrap a signed open angle into [0, cycle]
  function automatic logic [15:0] wrap_start(input logic signed [16:0] v);
    logic signed [19:0] w;
    w = 20'(v);
    if (w > CYCLE_UNITS) begin
      w = w - CYCLE_UNITS;
    end else if (w < 0) begin
      w = w + CYCLE_UNITS;
      if (w < 0) begin
        w = w + CYCLE_UNITS;
      end
    end
    return w[15:0];
  endfunction

  // wrap the angle to travel into [0, cycle]; the input lies at most 1440 degrees outside
  function automatic logic [15:0] wrap_deg(input logic signed [19:0] v);
    logic signed [19:0] w;
    w = v;
    if (w > CYCLE_UNITS) begin
      w = w - CYCLE_UNITS;
      if (w > CYCLE_UNITS) begin
        w = w - CYCLE_UNITS;
      end
    end else if (w < 0) begin
      w = w + CYCLE_UNITS;
      if (w < 0) begin
        w = w + CYCLE_UNITS;
      end
    end
    return w[15:0];
  endfunction

  // a at or before b on the wrapping timer
  function automatic logic tick_le(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = b - a;
    return !d[31];
  endfunction

  // a strictly before b on the wrapping timer
  function automatic logic tick_lt(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = b - a;
    return (d != 32'd0) && !d[31];
  endfunction

endpackage

FILE: rtl/injector_angle_to_tick_scheduler_top.sv
// ----------------------------------------------------------------------------
// injector_angle_to_tick_scheduler_top
// Turns injector requests into open and close ticks on a 32-bit timer.
// ----------------------------------------------------------------------------
// One request in, one result out, in order. The front registers each request,
// picks crank or cam as angle source and wraps the open angle and the angle
// still to travel into the 720-degree cycle; a two-entry queue then hands the
// request to the back, which works one request at a time. A request that needs
// ticks goes through take, multiply, four reciprocal steps and decide: the
// pulse-to-tick conversion divides by a million through a constant reciprocal
// multiplied in 21-bit pieces, one piece a cycle. A request that ends at once
// (no sync, bad index, zero pulse) goes from take to decide. Until the
// queue is full, the front takes requests while the back works and while a
// result waits in the output register. Registers sit on an APB-style port at
// byte address 4*i: injector count, timer ticks per second, then the six TDC
// angles; write them only while the block is idle. Per-injector close records
// stand in for the timer's scheduled flag; the timer is taken to accept all.
// ----------------------------------------------------------------------------
module injector_angle_to_tick_scheduler_top (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // requests
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               crank_synced,
  input  logic               cam_synced,
  input  logic [7:0]         crank_resolution,
  input  logic [7:0]         cam_resolution,
  input  logic [14:0]        crank_angle,
  input  logic [14:0]        cam_angle,
  input  logic [31:0]        crank_ticks_per_degree,
  input  logic [31:0]        cam_ticks_per_degree,
  input  logic [31:0]        now_tick,
  input  logic [2:0]         injector_index,
  input  logic signed [16:0] open_angle,
  input  logic [19:0]        pulse_us,
  // results
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         action,
  output logic [31:0]        open_tick,
  output logic [31:0]        close_tick
);

  logic [2:0]           injector_count;
  logic [26:0]          ticks_per_second;
  iats_pkg::tdc_array_t tdc;
  iats_pkg::reg_idx_t   reg_sel;
  logic                 cfg_write;

  logic           push_valid;
  logic           push_ready;
  iats_pkg::job_t push_job;
  logic           pop_valid;
  logic           pop_ready;
  iats_pkg::job_t pop_job;

  assign pready    = 1'b1;
  assign reg_sel   = iats_pkg::reg_idx_t'(paddr[4:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  // register file; mask each write to the register's width
  always_ff @(posedge clk) begin
    if (rst) begin
      injector_count   <= iats_pkg::INJ_COUNT_RESET;
      ticks_per_second <= iats_pkg::TPS_RESET;
      tdc              <= '0;
    end else if (cfg_write) begin
      case (reg_sel)
        iats_pkg::REG_INJ_COUNT: injector_count   <= pwdata[2:0];
        iats_pkg::REG_TPS:       ticks_per_second <= pwdata[26:0];
        iats_pkg::REG_TDC0:      tdc[0]           <= pwdata[9:0];
        iats_pkg::REG_TDC1:      tdc[1]           <= pwdata[9:0];
        iats_pkg::REG_TDC2:      tdc[2]           <= pwdata[9:0];
        iats_pkg::REG_TDC3:      tdc[3]           <= pwdata[9:0];
        iats_pkg::REG_TDC4:      tdc[4]           <= pwdata[9:0];
        iats_pkg::REG_TDC5:      tdc[5]           <= pwdata[9:0];
        default:                 injector_count   <= injector_count;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_sel)
      iats_pkg::REG_INJ_COUNT: prdata = 32'(injector_count);
      iats_pkg::REG_TPS:       prdata = 32'(ticks_per_second);
      iats_pkg::REG_TDC0:      prdata = 32'(tdc[0]);
      iats_pkg::REG_TDC1:      prdata = 32'(tdc[1]);
      iats_pkg::REG_TDC2:      prdata = 32'(tdc[2]);
      iats_pkg::REG_TDC3:      prdata = 32'(tdc[3]);
      iats_pkg::REG_TDC4:      prdata = 32'(tdc[4]);
      iats_pkg::REG_TDC5:      prdata = 32'(tdc[5]);
      default:                 prdata = 32'd0;
    endcase
  end

  // classify and wrap
  iats_front u_front (
    .clk                    (clk),
    .rst                    (rst),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .crank_synced           (crank_synced),
    .cam_synced             (cam_synced),
    .crank_resolution       (crank_resolution),
    .cam_resolution         (cam_resolution),
    .crank_angle            (crank_angle),
    .cam_angle              (cam_angle),
    .crank_ticks_per_degree (crank_ticks_per_degree),
    .cam_ticks_per_degree   (cam_ticks_per_degree),
    .now_tick               (now_tick),
    .injector_index         (injector_index),
    .open_angle             (open_angle),
    .pulse_us               (pulse_us),
    .injector_count         (injector_count),
    .tdc                    (tdc),
    .push_valid             (push_valid),
    .push_ready             (push_ready),
    .push_job               (push_job)
  );

  // decouple front and back
  iats_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  // ticks, close record and result register
  iats_back u_back (
    .clk              (clk),
    .rst              (rst),
    .ticks_per_second (ticks_per_second),
    .pop_valid        (pop_valid),
    .pop_ready        (pop_ready),
    .pop_job          (pop_job),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .action           (action),
    .open_tick        (open_tick),
    .close_tick       (close_tick)
  );

endmodule

FILE: rtl/iats_front.sv
// ----------------------------------------------------------------------------
// iats_front
// Classify requests, pick the angle source and wrap the angles.
// ----------------------------------------------------------------------------
module iats_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     crank_synced,
  input  logic                     cam_synced,
  input  logic [7:0]               crank_resolution,
  input  logic [7:0]               cam_resolution,
  input  logic [14:0]              crank_angle,
  input  logic [14:0]              cam_angle,
  input  logic [31:0]              crank_ticks_per_degree,
  input  logic [31:0]              cam_ticks_per_degree,
  input  logic [31:0]              now_tick,
  input  logic [2:0]               injector_index,
  input  logic signed [16:0]       open_angle,
  input  logic [19:0]              pulse_us,
  input  logic [2:0]               injector_count,
  input  iats_pkg::tdc_array_t     tdc,
  output logic                     push_valid,
  input  logic                     push_ready,
  output iats_pkg::job_t           push_job
);

  logic               a_valid;
  iats_pkg::kind_t    a_kind;
  logic [2:0]         a_idx;
  logic [32:0]        a_tpd;
  logic [15:0]        a_pos;
  logic [15:0]        a_start;
  logic [31:0]        a_now;
  logic [19:0]        a_pulse;

  logic               use_crank;
  logic [2:0]         limit;
  iats_pkg::kind_t    kind_next;
  logic [15:0]        pos_next;
  logic [32:0]        tpd_next;
  logic [9:0]         tdc_sel;
  logic signed [19:0] travel;

  assign in_ready   = !a_valid || push_ready;
  assign push_valid = a_valid;

  always_comb begin
    use_crank = crank_synced && cam_synced &&
                ({1'b0, cam_resolution} <= {crank_resolution, 1'b0});
    limit = (injector_count > 3'(iats_pkg::MAX_INJECTORS)) ?
            3'(iats_pkg::MAX_INJECTORS) : injector_count;
    if (use_crank) begin
      pos_next = {1'b0, crank_angle} +
                 ((cam_angle >= iats_pkg::CAM_HALF_UNITS) ? iats_pkg::DEG360_UNITS : 16'd0);
      tpd_next = {1'b0, crank_ticks_per_degree};
    end else begin
      pos_next = {cam_angle, 1'b0};
      tpd_next = {cam_ticks_per_degree, 1'b0};
    end
    if (!use_crank && !cam_synced) begin
      kind_next = iats_pkg::K_NOSYNC;
    end else if (injector_index >= limit) begin
      kind_next = iats_pkg::K_BADIDX;
    end else if (pulse_us == 20'd0) begin
      kind_next = iats_pkg::K_CANCEL;
    end else begin
      kind_next = iats_pkg::K_RUN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      a_kind  <= kind_next;
      a_idx   <= injector_index;
      a_tpd   <= tpd_next;
      a_pos   <= pos_next;
      a_start <= iats_pkg::wrap_start(open_angle);
      a_now   <= now_tick;
      a_pulse <= pulse_us;
    end
  end

  // angle still to travel: tdc + start - position, wrapped
  always_comb begin
    tdc_sel = (a_idx < 3'(iats_pkg::MAX_INJECTORS)) ? tdc[a_idx] : 10'd0;
    travel  = $signed({4'b0, tdc_sel, 6'b0}) + $signed({4'b0, a_start}) -
              $signed({4'b0, a_pos});
    push_job.kind  = a_kind;
    push_job.idx   = a_idx;
    push_job.tpd   = a_tpd;
    push_job.deg   = iats_pkg::wrap_deg(travel);
    push_job.now   = a_now;
    push_job.pulse = a_pulse;
  end

endmodule

FILE: rtl/iats_queue.sv
// ----------------------------------------------------------------------------
// iats_queue
// Two-entry queue of classified requests between front and back.
// ----------------------------------------------------------------------------
module iats_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  iats_pkg::job_t push_job,
  output logic           pop_valid,
  input  logic           pop_ready,
  output iats_pkg::job_t pop_job
);

  iats_pkg::job_t mem [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_job    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

endmodule

FILE: rtl/iats_back.sv
// ----------------------------------------------------------------------------
// iats_back
// Compute ticks, check the close record, register the result.
// ----------------------------------------------------------------------------
module iats_back (
  input  logic           clk,
  input  logic           rst,
  input  logic [26:0]    ticks_per_second,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  iats_pkg::job_t pop_job,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [2:0]     action,
  output logic [31:0]    open_tick,
  output logic [31:0]    close_tick
);

  iats_pkg::bstate_t state;
  iats_pkg::bstate_t state_next;
  iats_pkg::job_t    j;

  logic [48:0] open_prod;
  logic [41:0] half_prod;
  logic [46:0] pulse_prod;
  logic [81:0] acc;
  logic [2:0]  cnt;
  logic [31:0] open_t;
  logic [31:0] half_t;

  logic [31:0] close_time [iats_pkg::MAX_INJECTORS];
  logic [iats_pkg::MAX_INJECTORS-1:0] close_pending;

  logic        out_load;
  logic [40:0] y_w;
  logic [20:0] y_part;
  logic [20:0] m_part;
  logic [41:0] pp;
  logic [81:0] pp_sh;
  logic [31:0] quo;
  logic [49:0] open_rnd;
  logic [42:0] half_rnd;
  logic [2:0]  rd_idx;
  logic [31:0] close_t;
  logic        pending;
  iats_pkg::action_t act;
  logic        rec_write;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      iats_pkg::B_IDLE: begin
        if (pop_valid) begin
          state_next = (pop_job.kind == iats_pkg::K_RUN) ? iats_pkg::B_MUL : iats_pkg::B_DECIDE;
        end
      end
      iats_pkg::B_MUL:    state_next = iats_pkg::B_DIV;
      iats_pkg::B_DIV: begin
        if (cnt == iats_pkg::DIV_LAST_STEP) begin
          state_next = iats_pkg::B_DECIDE;
        end
      end
      iats_pkg::B_DECIDE: begin
        if (out_load) begin
          state_next = iats_pkg::B_IDLE;
        end
      end
      default:            state_next = iats_pkg::B_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop_ready = (state == iats_pkg::B_IDLE);
    out_load  = (state == iats_pkg::B_DECIDE) && (!out_valid || out_ready);
  end

  // reciprocal product of the shifted pulse product, one 21-bit piece a step
  always_comb begin
    y_w    = pulse_prod[46:6];
    y_part = cnt[1] ? {1'b0, y_w[40:21]} : y_w[20:0];
    m_part = cnt[0] ? iats_pkg::RECIP_HI : iats_pkg::RECIP_LO;
    pp     = 42'(y_part) * 42'(m_part);
    case (cnt[1:0])
      2'd0:    pp_sh = 82'(pp);
      2'd3:    pp_sh = 82'(pp) << 42;
      default: pp_sh = 82'(pp) << 21;
    endcase
    quo      = 32'(acc[81:54]);
    open_rnd = {1'b0, open_prod} + 50'(1 << 21);
    half_rnd = {1'b0, half_prod} + 43'h8000;
  end

  // decision on the close record
  always_comb begin
    rd_idx  = (j.idx < 3'(iats_pkg::MAX_INJECTORS)) ? j.idx : 3'd0;
    close_t = open_t + quo;
    pending = close_pending[rd_idx] && !iats_pkg::tick_le(close_time[rd_idx], j.now);
    case (j.kind)
      iats_pkg::K_NOSYNC: act = iats_pkg::ACT_NONE;
      iats_pkg::K_BADIDX: act = iats_pkg::ACT_BAD_INDEX;
      iats_pkg::K_CANCEL: act = iats_pkg::ACT_CANCEL;
      default: begin
        if ((j.deg > iats_pkg::HALF_CYCLE_UNITS) && pending &&
            iats_pkg::tick_lt(close_time[rd_idx], open_t - half_t)) begin
          act = iats_pkg::ACT_SKIP_PENDING;
        end else if (iats_pkg::tick_le(open_t, j.now)) begin
          act = iats_pkg::ACT_SKIP_PASSED;
        end else if (iats_pkg::tick_le(close_t, j.now)) begin
          act = iats_pkg::ACT_OPEN_ONLY;
        end else begin
          act = iats_pkg::ACT_OPEN_CLOSE;
        end
      end
    endcase
    rec_write = out_load && (act == iats_pkg::ACT_OPEN_CLOSE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= iats_pkg::B_IDLE;
      out_valid     <= 1'b0;
      close_pending <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (rec_write) begin
        close_pending[rd_idx] <= 1'b1;
      end
    end
    if (pop_valid && pop_ready) begin
      j <= pop_job;
    end
    if (state == iats_pkg::B_MUL) begin
      open_prod  <= 49'(j.tpd) * 49'(j.deg);
      half_prod  <= 42'(j.tpd) * 42'(iats_pkg::DEG360);
      pulse_prod <= 47'(j.pulse) * 47'(ticks_per_second) + iats_pkg::PULSE_ROUND;
      cnt        <= 3'd0;
    end
    if (state == iats_pkg::B_DIV) begin
      acc <= ((cnt == 3'd0) ? 82'd0 : acc) + pp_sh;
      cnt <= cnt + 3'd1;
      if (cnt == 3'd0) begin
        open_t <= j.now + 32'(open_rnd[49:22]);
        half_t <= 32'(half_rnd[42:16]);
      end
    end
    if (rec_write) begin
      close_time[rd_idx] <= close_t;
    end
    if (out_load) begin
      action     <= act;
      open_tick  <= (j.kind == iats_pkg::K_RUN) ? open_t : 32'd0;
      close_tick <= ((act == iats_pkg::ACT_OPEN_ONLY) || (act == iats_pkg::ACT_OPEN_CLOSE)) ?
                    close_t : 32'd0;
    end
  end

  a_mul_to_div: assert property (@(posedge clk) disable iff (rst)
    state == iats_pkg::B_MUL |=> state == iats_pkg::B_DIV && cnt == 3'd1 - 3'd1)
    else $error("multiply step not followed by first divide step");

  a_div_run_only: assert property (@(posedge clk) disable iff (rst)
    state == iats_pkg::B_DIV |-> j.kind == iats_pkg::K_RUN)
    else $error("divider entered for a request that needs no ticks");

  a_record_set: assert property (@(posedge clk) disable iff (rst)
    rec_write |=> close_pending[$past(rd_idx)] && out_valid)
    else $error("close record not set after open and close");

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// Injector scheduler testbench
// Drives injector requests through the valid/ready port with random gaps and
// output stalls, predicts each result from its own copy of the registers and
// per-injector close records, and checks every result field in order.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic               crank_synced;
    logic               cam_synced;
    logic [7:0]         crank_resolution;
    logic [7:0]         cam_resolution;
    logic [14:0]        crank_angle;
    logic [14:0]        cam_angle;
    logic [31:0]        crank_tpd;
    logic [31:0]        cam_tpd;
    logic [31:0]        now_tick;
    logic [2:0]         injector_index;
    logic signed [16:0] open_angle;
    logic [19:0]        pulse_us;
  } request_t;

  typedef struct {
    iats_pkg::action_t act;
    logic [31:0]       open_t;
    logic [31:0]       close_t;
  } schedule_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  request_t req_drv = '{default: '0};
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] action;
  logic [31:0] open_tick, close_tick;

  injector_angle_to_tick_scheduler_top uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .crank_synced(req_drv.crank_synced), .cam_synced(req_drv.cam_synced),
    .crank_resolution(req_drv.crank_resolution),
    .cam_resolution(req_drv.cam_resolution),
    .crank_angle(req_drv.crank_angle), .cam_angle(req_drv.cam_angle),
    .crank_ticks_per_degree(req_drv.crank_tpd),
    .cam_ticks_per_degree(req_drv.cam_tpd),
    .now_tick(req_drv.now_tick), .injector_index(req_drv.injector_index),
    .open_angle(req_drv.open_angle), .pulse_us(req_drv.pulse_us),
    .out_valid(out_valid), .out_ready(out_ready),
    .action(action), .open_tick(open_tick), .close_tick(close_tick)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // predictor state: register shadow and per-injector close records
  logic [2:0]  inj_count_sh;
  logic [26:0] tps_sh;
  logic [9:0]  tdc_sh [iats_pkg::MAX_INJECTORS];
  logic [31:0] close_at [iats_pkg::MAX_INJECTORS];
  logic        close_armed [iats_pkg::MAX_INJECTORS];

  request_t  pending_requests[$];
  schedule_t expected_schedules[$];
  int  n_fail = 0;
  int  n_checked = 0;
  int  n_sent = 0;
  int  act_seen [7];
  bit  hold_sender = 1'b0;

  // wrap into (0, cycle] above, [0, cycle) below; exact cycle stays
  function automatic longint cycle_wrap(longint v);
    longint c;
    c = 720 * 64;
    if (v > c) return ((v - 1) % c) + 1;
    if (v < 0) return c - 1 - ((-v - 1) % c);
    return v;
  endfunction

  function automatic bit before_or_at(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = b - a;
    return d < 32'h8000_0000;
  endfunction

  function automatic bit strictly_before(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = b - a;
    return d != 0 && d < 32'h8000_0000;
  endfunction

  function automatic schedule_t predict_schedule(request_t r);
    schedule_t s;
    longint pos, start, deg;
    logic [63:0] tpd, prod;
    logic [31:0] open_t, close_t, half_t;
    int lim;
    bit busy;
    s = '{iats_pkg::ACT_NONE, 32'd0, 32'd0};
    if (r.cam_synced && r.crank_synced &&
        {1'b0, r.cam_resolution} <= {r.crank_resolution, 1'b0}) begin
      pos = r.crank_angle;
      if (r.cam_angle >= 180 * 64) pos += 360 * 64;
      tpd = r.crank_tpd;
    end else if (r.cam_synced) begin
      pos = 2 * longint'(r.cam_angle);
      tpd = 64'(r.cam_tpd) * 2;
    end else begin
      return s;
    end
    lim = inj_count_sh > iats_pkg::MAX_INJECTORS ? iats_pkg::MAX_INJECTORS : inj_count_sh;
    if (r.injector_index >= lim) begin
      s.act = iats_pkg::ACT_BAD_INDEX;
      return s;
    end
    if (r.pulse_us == 0) begin
      s.act = iats_pkg::ACT_CANCEL;
      return s;
    end
    start = cycle_wrap(longint'(r.open_angle));
    deg = cycle_wrap(longint'(tdc_sh[r.injector_index]) * 64 + start - pos);
    prod = (tpd * 64'(deg) + (64'd1 << 21)) >> 22;
    open_t = r.now_tick + prod[31:0];
    s.open_t = open_t;
    prod = (tpd * 360 + 64'h8000) >> 16;
    half_t = prod[31:0];
    busy = close_armed[r.injector_index] &&
           !before_or_at(close_at[r.injector_index], r.now_tick);
    if (deg > 360 * 64 && busy &&
        strictly_before(close_at[r.injector_index], open_t - half_t)) begin
      s.act = iats_pkg::ACT_SKIP_PENDING;
      return s;
    end
    if (before_or_at(open_t, r.now_tick)) begin
      s.act = iats_pkg::ACT_SKIP_PASSED;
      return s;
    end
    prod = (64'(r.pulse_us) * 64'(tps_sh) + 64'd500000) / 64'd1000000;
    close_t = open_t + prod[31:0];
    s.close_t = close_t;
    if (before_or_at(close_t, r.now_tick)) begin
      s.act = iats_pkg::ACT_OPEN_ONLY;
      return s;
    end
    close_at[r.injector_index] = close_t;
    close_armed[r.injector_index] = 1'b1;
    s.act = iats_pkg::ACT_OPEN_CLOSE;
    return s;
  endfunction

  // driver: present the queue head, hold it until taken, then idle a random gap, possibly none
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_schedules.push_back(predict_schedule(req_drv));
        n_sent++;
        gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
        if (gap_left == 0 && pending_requests.size() != 0 && !hold_sender) begin
          req_drv <= pending_requests.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end else if (!in_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_requests.size() != 0 && !hold_sender) begin
          req_drv <= pending_requests.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  // monitor: random back-pressure, check each taken result against the oldest
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_schedules.size() == 0) begin
          $display("%0t: unexpected result action=%0d", $realtime, action);
          n_fail++;
        end else begin
          schedule_t e;
          e = expected_schedules.pop_front();
          act_seen[e.act]++;
          n_checked++;
          if (action !== e.act || open_tick !== e.open_t || close_tick !== e.close_t) begin
            $display("%0t: mismatch expected act=%0d open=%h close=%h got act=%0d open=%h close=%h",
                     $realtime, e.act, e.open_t, e.close_t, action, open_tick, close_tick);
            n_fail++;
          end
        end
        stall_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 18);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic wait_drained();
    while (pending_requests.size() != 0 || in_valid || expected_schedules.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic apb_write(iats_pkg::reg_idx_t r, logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {r, 2'b00}; pwdata <= v; penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (r)
      iats_pkg::REG_INJ_COUNT: inj_count_sh = v[2:0];
      iats_pkg::REG_TPS:       tps_sh = v[26:0];
      default:                 tdc_sh[int'(r) - int'(iats_pkg::REG_TDC0)] = v[9:0];
    endcase
  endtask

  // mostly plausible engine positions, with occasional wild fields
  function automatic request_t random_request();
    request_t r;
    r.crank_synced = $urandom_range(0, 7) != 0;
    r.cam_synced = $urandom_range(0, 5) != 0;
    r.crank_resolution = 8'($urandom);
    r.cam_resolution = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 40));
    r.crank_angle = 15'($urandom_range(0, 23039));
    r.cam_angle = 15'($urandom_range(0, 23039));
    r.crank_tpd = $urandom_range(0, 5) == 0 ? 32'($urandom) : 32'($urandom_range(1, 1 << 22));
    r.cam_tpd = $urandom_range(0, 5) == 0 ? 32'($urandom) : 32'($urandom_range(1, 1 << 22));
    r.now_tick = $urandom;
    r.injector_index = $urandom_range(0, 7) == 0 ? 3'($urandom_range(6, 7)) :
                                                   3'($urandom_range(0, 5));
    r.open_angle = 17'(int'($urandom_range(0, 92160)) - 46080);
    r.pulse_us = $urandom_range(0, 15) == 0 ? 20'd0 :
                 ($urandom_range(0, 9) == 0 ? 20'($urandom_range(0, 1048575)) :
                                              20'($urandom_range(1, 20000)));
    return r;
  endfunction

  initial begin
    request_t r;
    inj_count_sh = iats_pkg::INJ_COUNT_RESET;
    tps_sh = iats_pkg::TPS_RESET;
    foreach (tdc_sh[i]) tdc_sh[i] = '0;
    foreach (close_at[i]) begin
      close_at[i] = '0;
      close_armed[i] = 1'b0;
    end
    foreach (act_seen[i]) act_seen[i] = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: every sync combination, bad indices, extremes, wrap edges, zero pulse
    for (int k = 0; k < 22; k++) begin
      r = random_request();
      r.injector_index = 3'(k % 4);
      case (k)
        0: begin r.crank_synced = 0; r.cam_synced = 0; end
        1: begin r.crank_synced = 1; r.cam_synced = 0; end
        2: begin r.crank_synced = 0; r.cam_synced = 1; r.cam_angle = 15'h7fff; end
        3: begin r.crank_synced = 1; r.cam_synced = 1; r.cam_resolution = 8'hff;
                 r.crank_resolution = 0; end
        4: begin r.crank_synced = 1; r.cam_synced = 1; r.crank_angle = 15'h7fff;
                 r.cam_angle = 11520; r.crank_resolution = 8'hff; end
        5: r.pulse_us = 0;
        6: r.injector_index = 3'd7;
        7: r.injector_index = 3'd4;
        8: r.open_angle = 17'sd46080;
        9: r.open_angle = -17'sd46080;
        10: r.open_angle = -17'sd65536;
        11: r.open_angle = 17'sd65535;
        12: begin r.crank_tpd = 32'hffff_ffff; r.cam_tpd = 32'hffff_ffff; end
        13: begin r.crank_tpd = 0; r.cam_tpd = 0; end
        14: r.pulse_us = 20'hfffff;
        15: r.now_tick = 32'hffff_ffff;
        16: r.now_tick = 0;
        17: begin r.crank_resolution = 8'hff; r.cam_resolution = 8'hff; end
        default: ;
      endcase
      pending_requests.push_back(r);
    end
    wait_drained();

    // phases across settings, ending each once idle; the drain doubles as a
    // sender pause until every expected result has come
    for (int ph = 0; ph < 6; ph++) begin
      apb_write(iats_pkg::REG_INJ_COUNT, ph == 0 ? 32'd6 : (ph == 1 ? 32'd1 :
                               (ph == 2 ? 32'd7 : 32'($urandom_range(1, 6)))));
      apb_write(iats_pkg::REG_TPS, ph == 1 ? 32'd1 : (ph == 2 ? 32'd100000000 :
                                           32'($urandom_range(1, 100000000))));
      for (int t = 0; t < iats_pkg::MAX_INJECTORS; t++)
        apb_write(iats_pkg::reg_idx_t'(int'(iats_pkg::REG_TDC0) + t),
                  ph == 1 ? 32'd0 : (ph == 2 ? 32'd719 : 32'($urandom_range(0, 719))));
      for (int k = 0; k < 325; k++) begin
        r = random_request();
        pending_requests.push_back(r);
        // once in each phase, hold the sender until the block has caught up
        if (k == 160) begin
          while (pending_requests.size() != 0 || in_valid) @(posedge clk);
          hold_sender = 1'b1;
          while (expected_schedules.size() != 0) @(posedge clk);
          hold_sender = 1'b0;
        end
      end
      wait_drained();
    end

    $display("Sent %0d requests, checked %0d results over six register settings.",
             n_sent, n_checked);
    $display("Actions none/cancel/pending/passed/open/both/badidx: %0d %0d %0d %0d %0d %0d %0d",
             act_seen[0], act_seen[1], act_seen[2], act_seen[3], act_seen[4],
             act_seen[5], act_seen[6]);
    if (n_fail == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog: far above the slowest legal run
  initial begin
    #3000000;
    $display("Timeout");
    $display("Test completed with failures");
    $finish;
  end

endmodule
